// File: hw/rtl/hht_pkg.sv
// ----------------------------------------------------------------------------
// hht_pkg
// Shared constants, result codes and the command/status bundles that join
// the hopscotch table controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hht_pkg;

  localparam int TableSizeDef  = 512;
  localparam int HopSpanDef    = 32;
  localparam int ProbeSpanDef  = 256;
  localparam int StoreDepthDef = 768;

  localparam int KeyW   = 31;
  localparam int ValueW = 32;

  // Result codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NO_ROOM  = 2'd2,
    ST_LOOKUP   = 2'd3
  } status_t;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    div_step;
    logic    clr_step;
    logic    idx_clr;
    logic    idx_inc;
    logic    key_rd;
    logic    take_free;
    logic    map_rd_home;
    logic    place_wr;
    logic    d_init;
    logic    d_dec;
    logic    map_rd_m;
    logic    pull_move;
    logic    pull_copy;
    logic    pull_clr;
    logic    res_set;
    status_t res_status;
    logic    res_found;
  } hht_cmd_t;

  // Status flags from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic key_zero;
    logic op_lookup;
    logic scan_end;
    logic probe_end;
    logic key_hit;
    logic key_empty;
    logic near;
    logic d_zero;
    logic free_lt_d;
    logic cand_any;
    logic out_free;
  } hht_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/hht_dp.sv
// ----------------------------------------------------------------------------
// hht_dp
// Datapath: item registers, home bucket reduction, slot stores, neighbourhood
// maps, probe and relocation counters and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hht_dp
  import hht_pkg::*;
#(
  parameter int TABLE_SIZE  = TableSizeDef,
  parameter int HOP_SPAN    = HopSpanDef,
  parameter int PROBE_SPAN  = ProbeSpanDef,
  parameter int STORE_DEPTH = StoreDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hht_cmd_t          cmd,
  output hht_stat_t              stat,
  input  wire logic              op,
  input  wire logic [KeyW-1:0]   key,
  input  wire logic [ValueW-1:0] value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic                   found
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int IW = $clog2(STORE_DEPTH + TABLE_SIZE + PROBE_SPAN + HOP_SPAN);
  localparam int TW = $clog2(TABLE_SIZE);
  localparam int DW = $clog2(PROBE_SPAN + 1);
  localparam int HW = $clog2(HOP_SPAN);

  // Reciprocal of TABLE_SIZE, rounded up, exact for every key of KeyW bits.
  localparam int          SH    = KeyW + TW;
  localparam logic [31:0] RECIP = 32'(((64'd1 << SH) + 64'(TABLE_SIZE) - 64'd1)
                                      / 64'(TABLE_SIZE));

  // Memories.
  logic [KeyW-1:0]     key_mem [STORE_DEPTH];
  logic [ValueW-1:0]   val_mem [STORE_DEPTH];
  logic [HOP_SPAN-1:0] map_mem [STORE_DEPTH];
  logic [KeyW-1:0]     krd;
  logic [ValueW-1:0]   vrd;
  logic [HOP_SPAN-1:0] mrd;

  // Item and working registers.
  logic              op_q;
  logic [KeyW-1:0]   key_q;
  logic [ValueW-1:0] val_q;
  logic [KeyW+31:0]  prod;
  logic              div_cnt;
  logic [TW-1:0]     home;
  logic [DW-1:0]     idx;
  logic [AW-1:0]     free;
  logic [HW-1:0]     d;
  logic [AW-1:0]     m;
  logic [HW-1:0]     cand_i;
  logic [AW-1:0]     clr_idx;

  logic [KeyW-1:0]   quo;
  logic [IW-1:0]     slot;
  logic [HW-1:0]     lo_i;
  logic              lo_any;
  logic [AW-1:0]     src_new;
  logic [AW-1:0]     src_old;
  logic [AW-1:0]     home_a;

  assign quo     = KeyW'(prod >> SH);
  assign slot    = IW'(home) + IW'(idx);
  assign home_a  = AW'(home);
  assign src_new = m + AW'(lo_i);
  assign src_old = m + AW'(cand_i);

  // Lowest occupied neighbour below the candidate distance.
  always_comb begin
    lo_i   = '0;
    lo_any = 1'b0;
    for (int j = HOP_SPAN - 1; j >= 0; j--) begin
      if (mrd[j] && (HW'(j) < d)) begin
        lo_i   = HW'(j);
        lo_any = 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.clr_done  = (clr_idx == AW'(STORE_DEPTH - 1));
    stat.div_done  = div_cnt;
    stat.key_zero  = (key_q == '0);
    stat.op_lookup = (op_q == OP_LOOKUP);
    stat.scan_end  = (idx == DW'(HOP_SPAN)) || (slot >= IW'(STORE_DEPTH));
    stat.probe_end = (idx == DW'(PROBE_SPAN)) || (slot >= IW'(STORE_DEPTH));
    stat.key_hit   = (krd == key_q);
    stat.key_empty = (krd == '0);
    stat.near      = (idx < DW'(HOP_SPAN));
    stat.d_zero    = (d == '0);
    stat.free_lt_d = (free < AW'(d));
    stat.cand_any  = lo_any;
    stat.out_free  = !out_valid || !out_stall;
  end

  // Item capture, home bucket and counters. The home bucket takes two steps:
  // the quotient by reciprocal multiplication, then the remainder.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= op;
      key_q   <= key;
      val_q   <= value;
      div_cnt <= 1'b0;
      home    <= '0;
    end
    if (cmd.div_step) begin
      if (!div_cnt) begin
        prod <= (KeyW+32)'(key_q) * (KeyW+32)'(RECIP);
      end else begin
        home <= TW'(key_q - KeyW'(quo * KeyW'(TABLE_SIZE)));
      end
      div_cnt <= 1'b1;
    end
    if (cmd.idx_clr) idx <= '0;
    if (cmd.idx_inc) idx <= idx + DW'(1);
    if (cmd.take_free) free <= AW'(slot);
    if (cmd.d_init) d <= HW'(HOP_SPAN - 1);
    if (cmd.d_dec) d <= d - HW'(1);
    if (cmd.map_rd_m) m <= free - AW'(d);
    if (cmd.pull_move) cand_i <= lo_i;
    if (cmd.pull_copy) begin
      free <= src_old;
      idx  <= idx - (DW'(d) - DW'(cand_i));
    end
  end

  // Clearing pass counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clr_step) begin
      clr_idx <= clr_idx + AW'(1);
    end
  end

  // Key store: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.key_rd) krd <= key_mem[AW'(slot)];
    if (cmd.pull_move) krd <= key_mem[src_new];
    if (cmd.clr_step) key_mem[clr_idx] <= '0;
    if (cmd.place_wr) key_mem[free] <= key_q;
    if (cmd.pull_copy) key_mem[free] <= krd;
    if (cmd.pull_clr) key_mem[free] <= '0;
  end

  // Value store.
  always_ff @(posedge clk) begin
    if (cmd.pull_move) vrd <= val_mem[src_new];
    if (cmd.place_wr) val_mem[free] <= val_q;
    if (cmd.pull_copy) val_mem[free] <= vrd;
  end

  // Neighbourhood maps.
  always_ff @(posedge clk) begin
    if (cmd.map_rd_home) mrd <= map_mem[home_a];
    if (cmd.map_rd_m) mrd <= map_mem[free - AW'(d)];
    if (cmd.clr_step) map_mem[clr_idx] <= '0;
    if (cmd.place_wr) map_mem[home_a] <= mrd | (HOP_SPAN'(1) << idx[HW-1:0]);
    if (cmd.pull_move)
      map_mem[m] <= (mrd | (HOP_SPAN'(1) << d)) & ~(HOP_SPAN'(1) << lo_i);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_set) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      status <= cmd.res_status;
      found  <= cmd.res_found;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hht_ctrl.sv
// ----------------------------------------------------------------------------
// hht_ctrl
// Controller: sequences the clearing pass, home division, neighbourhood
// scan, linear probe and the relocation steps of an insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hht_ctrl
  import hht_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire hht_stat_t stat,
  output hht_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DIV, S_SCAN_RD, S_SCAN_CMP, S_PROBE_RD, S_PROBE_CMP,
    S_PLACE_CHK, S_PLACE_WR, S_PULL_RD, S_PULL_CHK, S_PULL_MV, S_PULL_CLR, S_FIN
  } state_t;

  state_t  state, state_next;
  status_t rs, rs_next;
  logic    rf, rf_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    rs_next        = rs;
    rf_next        = rf;
    cmd            = '0;
    cmd.res_status = rs;
    cmd.res_found  = rf;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cmd.idx_clr  = 1'b1;
        if (stat.div_done) begin
          if (stat.key_zero) begin
            rs_next    = stat.op_lookup ? ST_LOOKUP : ST_NO_ROOM;
            rf_next    = 1'b0;
            state_next = S_FIN;
          end else begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (stat.scan_end) begin
          if (stat.op_lookup) begin
            rs_next    = ST_LOOKUP;
            rf_next    = 1'b0;
            state_next = S_FIN;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_PROBE_RD;
          end
        end else begin
          cmd.key_rd = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.key_hit) begin
          rs_next    = stat.op_lookup ? ST_LOOKUP : ST_PRESENT;
          rf_next    = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_PROBE_RD: begin
        if (stat.probe_end) begin
          rs_next    = ST_NO_ROOM;
          rf_next    = 1'b0;
          state_next = S_FIN;
        end else begin
          cmd.key_rd = 1'b1;
          state_next = S_PROBE_CMP;
        end
      end
      S_PROBE_CMP: begin
        if (stat.key_empty) begin
          cmd.take_free = 1'b1;
          state_next    = S_PLACE_CHK;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_PROBE_RD;
        end
      end
      S_PLACE_CHK: begin
        if (stat.near) begin
          cmd.map_rd_home = 1'b1;
          state_next      = S_PLACE_WR;
        end else begin
          cmd.d_init = 1'b1;
          state_next = S_PULL_RD;
        end
      end
      S_PLACE_WR: begin
        cmd.place_wr = 1'b1;
        rs_next      = ST_INSERTED;
        rf_next      = 1'b0;
        state_next   = S_FIN;
      end
      S_PULL_RD: begin
        if (stat.d_zero) begin
          // No entry can move: the free slot is already empty.
          rs_next    = ST_NO_ROOM;
          rf_next    = 1'b0;
          state_next = S_FIN;
        end else if (stat.free_lt_d) begin
          cmd.d_dec = 1'b1;
        end else begin
          cmd.map_rd_m = 1'b1;
          state_next   = S_PULL_CHK;
        end
      end
      S_PULL_CHK: begin
        if (stat.cand_any) begin
          cmd.pull_move = 1'b1;
          state_next    = S_PULL_MV;
        end else begin
          cmd.d_dec  = 1'b1;
          state_next = S_PULL_RD;
        end
      end
      S_PULL_MV: begin
        cmd.pull_copy = 1'b1;
        state_next    = S_PULL_CLR;
      end
      S_PULL_CLR: begin
        cmd.pull_clr = 1'b1;
        state_next   = S_PLACE_CHK;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.res_set = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and registered result code.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      rs    <= ST_INSERTED;
      rf    <= 1'b0;
    end else begin
      state <= state_next;
      rs    <= rs_next;
      rf    <= rf_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hopscotch_hash_table_top.sv
// ----------------------------------------------------------------------------
// hopscotch_hash_table_top
// Hopscotch hash table of positive keys with insert and lookup.
//
//   Channel | Direction | Handshake          | Fields
//   in      | input     | in_valid/in_stall  | op, key, value
//   out     | output    | out_valid/out_stall| status, found
//
// One item at a time. The home bucket takes two steps (reciprocal multiply,
// then remainder), then the scan reads and compares each slot in turn, as
// set by the single key memory read port. Inserts add a read and a compare per
// probed slot; each relocation passes the place check, pull read, pull
// check, move and clear states, and each distance that offers no entry to
// move adds a read and a check. After reset a clearing pass over all
// STORE_DEPTH slots runs before the first transfer is taken. A stalled
// result holds; the next item may be accepted while it waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hopscotch_hash_table_top
  import hht_pkg::*;
#(
  parameter int TABLE_SIZE  = TableSizeDef,
  parameter int HOP_SPAN    = HopSpanDef,
  parameter int PROBE_SPAN  = ProbeSpanDef,
  parameter int STORE_DEPTH = StoreDepthDef
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              op,
  input  wire logic [KeyW-1:0]   key,
  input  wire logic [ValueW-1:0] value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic                   found
);

  hht_cmd_t  cmd;
  hht_stat_t stat;

  // Sequencer.
  hht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  hht_dp #(
    .TABLE_SIZE  (TABLE_SIZE),
    .HOP_SPAN    (HOP_SPAN),
    .PROBE_SPAN  (PROBE_SPAN),
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .key       (key),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .found     (found)
  );

endmodule

`default_nettype wire

// File: hw/rtl/hht_checker.sv
// ----------------------------------------------------------------------------
// hht_props
// Port level checks for the hopscotch hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hht_props
  import hht_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [1:0] status,
  input wire logic       found
);

  // No result is presented right after reset.
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  // Insert codes carry a consistent found flag.
  a_found_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_LOOKUP) |-> (found == (status == ST_PRESENT)))
    else $error("found flag disagrees with status");

  // One item in flight: a transfer in is followed by a busy cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind hopscotch_hash_table_top hht_props u_hht_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .found     (found)
);

`default_nettype wire

// File: sim/hht_checker.sv
// ----------------------------------------------------------------------------
// hht_checker
// Watches both channels of the hopscotch hash table, keeps its own copy of
// the table to predict every answer, and compares each result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hht_checker
  import hht_pkg::*;
#(
  parameter int TABLE_SIZE  = TableSizeDef,
  parameter int HOP_SPAN    = HopSpanDef,
  parameter int PROBE_SPAN  = ProbeSpanDef,
  parameter int STORE_DEPTH = StoreDepthDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              op,
  input  logic [KeyW-1:0]   key,
  input  logic [ValueW-1:0] value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status,
  input  logic              found,
  output int                fail_count,
  output int                pending,
  output int                answers_seen,
  output int                cnt_inserted,
  output int                cnt_present,
  output int                cnt_no_room,
  output int                cnt_hits,
  output int                cnt_moves
);

  typedef struct {
    status_t st;
    logic    fnd;
  } answer_t;

  // Shadow copy of the table.
  logic [31:0] tbl_keys [STORE_DEPTH];
  logic [31:0] tbl_vals [STORE_DEPTH];
  logic [31:0] tbl_maps [STORE_DEPTH];

  answer_t answer_q [$];

  function automatic logic [31:0] bit_of(int n);
    return (n < 32) ? (32'd1 << n) : 32'd0;
  endfunction

  // True if the key sits within HOP_SPAN slots of its home.
  function automatic logic key_nearby(logic [31:0] k, int home);
    for (int i = 0; i < HOP_SPAN; i++) begin
      if (home + i >= STORE_DEPTH) break;
      if (tbl_keys[home + i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Move the free slot towards home by one relocation; 0 if nothing can move.
  function automatic logic hop_free_slot(inout int free_slot, inout int span);
    int m;
    logic [31:0] map;
    for (int d = HOP_SPAN - 1; d > 0; d--) begin
      if (free_slot < d) continue;
      m = free_slot - d;
      map = tbl_maps[m];
      for (int i = 0; i < d; i++) begin
        if (map & bit_of(i)) begin
          tbl_maps[m] = (map | bit_of(d)) & ~bit_of(i);
          tbl_keys[free_slot] = tbl_keys[m + i];
          tbl_vals[free_slot] = tbl_vals[m + i];
          tbl_keys[m + i] = '0;
          free_slot = m + i;
          span -= d - i;
          cnt_moves++;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic answer_t table_insert(logic [31:0] k, logic [31:0] v);
    answer_t a;
    int home, span, slot;
    logic got;
    home = int'(k % TABLE_SIZE);
    got = 1'b0;
    slot = 0;
    a.fnd = 1'b0;
    a.st = ST_NO_ROOM;
    if (k == 0) return a;
    if (key_nearby(k, home)) begin
      a.st = ST_PRESENT;
      a.fnd = 1'b1;
      return a;
    end
    for (span = 0; span < PROBE_SPAN; span++) begin
      slot = home + span;
      if (slot >= STORE_DEPTH) break;
      if (tbl_keys[slot] == 0) begin
        got = 1'b1;
        break;
      end
    end
    if (!got) return a;
    forever begin
      if (span < HOP_SPAN && span < 32) begin
        tbl_maps[home] |= bit_of(span);
        tbl_keys[slot] = k;
        tbl_vals[slot] = v;
        a.st = ST_INSERTED;
        return a;
      end
      if (!hop_free_slot(slot, span)) begin
        tbl_keys[slot] = '0;
        return a;
      end
    end
  endfunction

  assign pending = answer_q.size();

  // Predict on each input transfer, compare on each result transfer.
  always @(posedge clk) begin
    answer_t exp_a;
    logic [31:0] k;
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        tbl_keys[i] = '0;
        tbl_maps[i] = '0;
      end
      answer_q.delete();
      fail_count = 0;
      answers_seen = 0;
      cnt_inserted = 0;
      cnt_present = 0;
      cnt_no_room = 0;
      cnt_hits = 0;
      cnt_moves = 0;
    end else begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (answer_q.size() == 0) begin
          $error("result transfer with no answer expected: status %0d found %0d",
                 status, found);
          fail_count++;
        end else begin
          exp_a = answer_q.pop_front();
          if (status !== exp_a.st) begin
            $error("status: expected %0d, got %0d", exp_a.st, status);
            fail_count++;
          end
          if (found !== exp_a.fnd) begin
            $error("found: expected %0d, got %0d", exp_a.fnd, found);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        k = {1'b0, key};
        if (op == OP_LOOKUP) begin
          exp_a.st = ST_LOOKUP;
          exp_a.fnd = (k != 0) && key_nearby(k, int'(k % TABLE_SIZE));
          if (exp_a.fnd) cnt_hits++;
        end else begin
          exp_a = table_insert(k, value);
          case (exp_a.st)
            ST_INSERTED: cnt_inserted++;
            ST_PRESENT:  cnt_present++;
            default:     cnt_no_room++;
          endcase
        end
        answer_q.push_back(exp_a);
      end
    end
  end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives inserts and lookups into the hopscotch hash table: a directed set of
// edge keys, then clustered random traffic that forces relocation and full
// neighbourhoods, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hht_pkg::*;

  localparam int NumRandom = 500;
  localparam int IdleLimit = 20000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = OP_INSERT;
  logic [KeyW-1:0]   key = '0;
  logic [ValueW-1:0] value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic              found;

  int fail_count, pending, answers_seen;
  int cnt_inserted, cnt_present, cnt_no_room, cnt_hits, cnt_moves;
  int idle_cycles = 0;
  logic [KeyW-1:0] used_keys [$];

  always #5 clk = ~clk;

  hopscotch_hash_table_top DUT (
    .clk, .rst, .in_valid, .in_stall, .op, .key, .value,
    .out_valid, .out_stall, .status, .found
  );

  hht_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .op, .key, .value,
    .out_valid, .out_stall, .status, .found,
    .fail_count, .pending, .answers_seen,
    .cnt_inserted, .cnt_present, .cnt_no_room, .cnt_hits, .cnt_moves
  );

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Key whose home bucket is the given one.
  function automatic logic [KeyW-1:0] key_at(int home);
    return KeyW'(home) + KeyW'(TableSizeDef) * KeyW'($urandom_range(0, 4194302));
  endfunction

  // One transfer on the input channel, with an optional gap before it.
  task automatic send(logic o, logic [KeyW-1:0] k, logic [ValueW-1:0] v);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    key <= k;
    value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == OP_INSERT && k != 0) used_keys.push_back(k);
  endtask

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Result side: random stalls, and one long hold once traffic is flowing.
  initial begin
    int g;
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && answers_seen >= 150) begin
        held = 1;
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
      end
      g = gap_len();
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int r, lim;
    logic [KeyW-1:0] k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme keys and values, key zero, duplicates, the overflow
    // region and a small crowded neighbourhood.
    send(OP_INSERT, {KeyW{1'b1}}, 32'h8000_0000);
    send(OP_LOOKUP, {KeyW{1'b1}}, 32'hFFFF_FFFF);
    send(OP_INSERT, '0, 32'h7FFF_FFFF);
    send(OP_LOOKUP, '0, '0);
    send(OP_INSERT, 31'd656565, 32'h1234_5678);
    send(OP_LOOKUP, 31'd656565, '0);
    send(OP_INSERT, 31'd656565, 32'h0BAD_F00D);
    send(OP_INSERT, 31'd1, 32'h7FFF_FFFF);
    send(OP_INSERT, 31'd511, 32'hFFFF_FFFF);
    send(OP_INSERT, 31'd1023, '0);
    send(OP_INSERT, 31'd1535, 32'hA5A5_A5A5);
    send(OP_LOOKUP, 31'd1535, '0);
    send(OP_LOOKUP, 31'd2047, '0);
    for (int i = 0; i < 6; i++) send(OP_INSERT, key_at(0), $urandom());
    send(OP_LOOKUP, 31'd512, '0);
    send(OP_LOOKUP, 31'h5555_5555, '0);

    // Random: clustered inserts, lookups of stored keys, duplicates, noise.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send(OP_INSERT, key_at($urandom_range(100, 102)), $urandom());
      end else if (r < 40) begin
        send(OP_INSERT, key_at($urandom_range(470, 511)), $urandom());
      end else if (r < 65 && used_keys.size() > 0) begin
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        send(OP_LOOKUP, k, $urandom());
      end else if (r < 75 && used_keys.size() > 0) begin
        k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        send(OP_INSERT, k, $urandom());
      end else if (r < 85) begin
        send(OP_LOOKUP, key_at($urandom_range(0, 511)), $urandom());
      end else begin
        send(logic'($urandom_range(0, 1)), KeyW'($urandom()), $urandom());
      end
    end
    in_valid <= 1'b0;

    // Drain, then allow the block to settle.
    lim = 0;
    while (pending != 0 && lim < IdleLimit) begin
      @(posedge clk);
      lim++;
    end
    repeat (2000) @(posedge clk);

    $display("Covered %0d answers: %0d inserted, %0d already present, %0d no room.",
             answers_seen, cnt_inserted, cnt_present, cnt_no_room);
    $display("Lookup hits %0d, relocations %0d, mismatches %0d.",
             cnt_hits, cnt_moves, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      if (pending != 0) $error("%0d expected answers never arrived", pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
